>>> rtl/mbtd_pkg.sv
// shared types and constants for the multichannel baseline threshold detector
// no dependencies; used by the interfaces and every rtl module
package mbtd_pkg;

  localparam int CH_W   = 4;   // channel tag
  localparam int SMP_W  = 10;  // converter sample
  localparam int CNT_W  = 5;   // channel_count register
  localparam int OFS_W  = 10;  // detect_offset register
  localparam int RCL_W  = 16;  // recal_interval register
  localparam int REM_W  = 8;   // remainder of sample / history depth (depth <= 256)
  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;

  localparam logic [CNT_W-1:0] CHANNEL_COUNT_RST  = CNT_W'(16);
  localparam logic [OFS_W-1:0] DETECT_OFFSET_RST  = OFS_W'(0);
  localparam logic [RCL_W-1:0] RECAL_INTERVAL_RST = RCL_W'(1000);

  typedef enum logic [1:0] {
    REG_CHANNEL_COUNT  = 2'd0,
    REG_DETECT_OFFSET  = 2'd1,
    REG_RECAL_INTERVAL = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0] channel_count;
    logic [OFS_W-1:0] detect_offset;
    logic [RCL_W-1:0] recal_interval;
  } cfg_t;

  // sample already split into quotient and remainder by the history depth
  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [SMP_W-1:0] sample;
    logic [SMP_W-1:0] quot;
    logic [REM_W-1:0] rem;
  } item_t;

endpackage

>>> rtl/mbtd_intf.sv
// valid/ready channel interfaces for sample requests and detection results
// depends on mbtd_pkg
interface mbtd_sample_if;
  logic                       valid;
  logic                       ready;
  logic [mbtd_pkg::CH_W-1:0]  channel;
  logic [mbtd_pkg::SMP_W-1:0] sample;

  modport source (output valid, channel, sample, input ready);
  modport sink   (input valid, channel, sample, output ready);
endinterface

interface mbtd_result_if;
  logic                      valid;
  logic                      ready;
  logic [mbtd_pkg::CH_W-1:0] result_channel;
  logic                      pressed;

  modport source (output valid, result_channel, pressed, input ready);
  modport sink   (input valid, result_channel, pressed, output ready);
endinterface

>>> rtl/mbtd_regs.sv
// apb configuration registers: channel_count, detect_offset, recal_interval
// depends on mbtd_pkg
module mbtd_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mbtd_pkg::ADDR_W-1:0]   paddr,
  input  logic [mbtd_pkg::DATA_W-1:0]   pwdata,
  output logic [mbtd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output mbtd_pkg::cfg_t                cfg
);

  mbtd_pkg::reg_idx_t idx;
  logic               wr;

  assign idx    = mbtd_pkg::reg_idx_t'(paddr[mbtd_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_count  <= mbtd_pkg::CHANNEL_COUNT_RST;
      cfg.detect_offset  <= mbtd_pkg::DETECT_OFFSET_RST;
      cfg.recal_interval <= mbtd_pkg::RECAL_INTERVAL_RST;
    end else if (wr) begin
      unique case (idx)
        mbtd_pkg::REG_CHANNEL_COUNT:
          cfg.channel_count <= pwdata[mbtd_pkg::CNT_W-1:0];
        mbtd_pkg::REG_DETECT_OFFSET:
          cfg.detect_offset <= pwdata[mbtd_pkg::OFS_W-1:0];
        mbtd_pkg::REG_RECAL_INTERVAL:
          cfg.recal_interval <= pwdata[mbtd_pkg::RCL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      mbtd_pkg::REG_CHANNEL_COUNT:  prdata = mbtd_pkg::DATA_W'(cfg.channel_count);
      mbtd_pkg::REG_DETECT_OFFSET:  prdata = mbtd_pkg::DATA_W'(cfg.detect_offset);
      mbtd_pkg::REG_RECAL_INTERVAL: prdata = mbtd_pkg::DATA_W'(cfg.recal_interval);
      default:                      prdata = '0;
    endcase
  end

endmodule

>>> rtl/mbtd_split.sv
// input register and two stages that split each sample into sample / depth
// and sample % depth (reciprocal multiply, then one correction step)
// depends on mbtd_pkg and mbtd_intf
module mbtd_split #(
  parameter int HISTORY_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  mbtd_sample_if.sink          samples,
  output logic                 item_valid,
  input  logic                 item_ready,
  output mbtd_pkg::item_t      item
);

  localparam int RECIP_SH = 20;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int PROD_W   = mbtd_pkg::SMP_W + RECIP_W;
  localparam int BACK_W   = mbtd_pkg::SMP_W + 9;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SH) / HISTORY_DEPTH);

  // stage 1: input register
  logic                         s1_valid;
  logic [mbtd_pkg::CH_W-1:0]    s1_channel;
  logic [mbtd_pkg::SMP_W-1:0]   s1_sample;
  // stage 2: quotient estimate, low by at most one
  logic                         s2_valid;
  logic [mbtd_pkg::CH_W-1:0]    s2_channel;
  logic [mbtd_pkg::SMP_W-1:0]   s2_sample;
  logic [mbtd_pkg::SMP_W-1:0]   s2_quot;

  logic s1_load, s2_load, s3_load;
  logic [PROD_W-1:0]          prod;
  logic [BACK_W-1:0]          back;
  logic [BACK_W-1:0]          rem0;
  logic                       fix;
  logic [mbtd_pkg::SMP_W-1:0] quot_fix;
  logic [BACK_W-1:0]          rem_fix;

  assign s3_load       = !item_valid || item_ready;
  assign s2_load       = !s2_valid || s3_load;
  assign s1_load       = !s1_valid || s2_load;
  assign samples.ready = s1_load;

  assign prod = PROD_W'(s1_sample) * PROD_W'(RECIP);

  assign back     = BACK_W'(s2_quot) * BACK_W'(HISTORY_DEPTH);
  assign rem0     = BACK_W'(s2_sample) - back;
  assign fix      = rem0 >= BACK_W'(HISTORY_DEPTH);
  assign quot_fix = s2_quot + mbtd_pkg::SMP_W'(fix);
  assign rem_fix  = fix ? rem0 - BACK_W'(HISTORY_DEPTH) : rem0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      item_valid <= 1'b0;
    end else begin
      if (s1_load) s1_valid   <= samples.valid;
      if (s2_load) s2_valid   <= s1_valid;
      if (s3_load) item_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_channel <= samples.channel;
      s1_sample  <= samples.sample;
    end
    if (s2_load) begin
      s2_channel <= s1_channel;
      s2_sample  <= s1_sample;
      s2_quot    <= prod[RECIP_SH +: mbtd_pkg::SMP_W];
    end
    if (s3_load) begin
      item.channel <= s2_channel;
      item.sample  <= s2_sample;
      item.quot    <= quot_fix;
      item.rem     <= rem_fix[mbtd_pkg::REM_W-1:0];
    end
  end

endmodule

>>> rtl/mbtd_core.sv
// per-channel calibration accumulators, baselines, round counters,
// threshold compare and the result register
// depends on mbtd_pkg and mbtd_intf
module mbtd_core #(
  parameter int MAX_CHANNELS  = 16,
  parameter int HISTORY_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  mbtd_pkg::cfg_t   cfg,
  input  logic             item_valid,
  output logic             item_ready,
  input  mbtd_pkg::item_t  item,
  mbtd_result_if.source    results
);

  localparam int TAG_CH  = 2 ** mbtd_pkg::CH_W;
  localparam int DEPTH   = (MAX_CHANNELS < TAG_CH) ? MAX_CHANNELS : TAG_CH;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NUM_W   = $clog2(MAX_CHANNELS + 1);
  localparam int CMP_W   = (NUM_W > mbtd_pkg::CNT_W) ? NUM_W : mbtd_pkg::CNT_W;
  localparam int RSTOR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int RSUM_W  = mbtd_pkg::REM_W + 1;
  localparam int ROUND_W = $clog2(HISTORY_DEPTH + 1);
  localparam int CMPV_W  = mbtd_pkg::SMP_W + 1;

  logic                               calibrating;
  logic [ROUND_W-1:0]                 calib_round;
  logic [mbtd_pkg::RCL_W-1:0]         detect_rounds;
  logic [mbtd_pkg::SMP_W-1:0]         acc_q    [DEPTH];
  logic [RSTOR_W-1:0]                 acc_r    [DEPTH];
  logic [mbtd_pkg::SMP_W-1:0]         baseline [DEPTH];

  logic                       consume;
  logic [CMP_W-1:0]           cnt_raw, num, ch_ext;
  logic                       in_use, last;
  logic [IDX_W-1:0]           idx;
  logic [RSUM_W-1:0]          rsum;
  logic                       carry;
  logic [RSTOR_W-1:0]         r_new;
  logic [mbtd_pkg::SMP_W-1:0] q_new;
  logic                       pressed;
  logic [ROUND_W-1:0]         round_inc;
  logic                       cal_done;
  logic [mbtd_pkg::RCL_W-1:0] dr_inc;
  logic                       recal;

  assign item_ready = !results.valid || results.ready;
  assign consume    = item_valid && item_ready;

  // effective channel count, saturated to 1..MAX_CHANNELS
  always_comb begin
    cnt_raw = CMP_W'(cfg.channel_count);
    if (cnt_raw == '0)                          num = CMP_W'(1);
    else if (cnt_raw > CMP_W'(MAX_CHANNELS))    num = CMP_W'(MAX_CHANNELS);
    else                                        num = cnt_raw;
  end

  assign ch_ext = CMP_W'(item.channel);
  assign in_use = ch_ext < num;
  assign last   = ch_ext == num - CMP_W'(1);
  assign idx    = item.channel[IDX_W-1:0];

  // running sum kept as quotient and remainder by the history depth
  assign rsum  = RSUM_W'(acc_r[idx]) + RSUM_W'(item.rem);
  assign carry = rsum >= RSUM_W'(HISTORY_DEPTH);
  assign r_new = carry ? RSTOR_W'(rsum - RSUM_W'(HISTORY_DEPTH)) : RSTOR_W'(rsum);
  assign q_new = acc_q[idx] + item.quot + mbtd_pkg::SMP_W'(carry);

  assign pressed = CMPV_W'(item.sample) >
                   (CMPV_W'(baseline[idx]) + CMPV_W'(cfg.detect_offset));

  assign round_inc = calib_round + ROUND_W'(1);
  assign cal_done  = round_inc == ROUND_W'(HISTORY_DEPTH);
  assign dr_inc    = detect_rounds + mbtd_pkg::RCL_W'(1);
  assign recal     = dr_inc == cfg.recal_interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      calibrating   <= 1'b1;
      calib_round   <= '0;
      detect_rounds <= '0;
      results.valid <= 1'b0;
      for (int c = 0; c < DEPTH; c++) begin
        acc_q[c]    <= '0;
        acc_r[c]    <= '0;
        baseline[c] <= '0;
      end
    end else begin
      if (item_ready) begin
        results.valid <= consume && in_use && !calibrating;
      end
      if (consume && in_use) begin
        if (calibrating) begin
          acc_q[idx] <= q_new;
          acc_r[idx] <= r_new;
          if (last) begin
            if (cal_done) begin
              for (int c = 0; c < DEPTH; c++) begin
                baseline[c] <= (IDX_W'(c) == idx) ? q_new : acc_q[c];
                acc_q[c]    <= '0;
                acc_r[c]    <= '0;
              end
              calibrating   <= 1'b0;
              calib_round   <= '0;
              detect_rounds <= '0;
            end else begin
              calib_round <= round_inc;
            end
          end
        end else if (last) begin
          if (recal) begin
            detect_rounds <= '0;
            calibrating   <= 1'b1;
            calib_round   <= '0;
            for (int c = 0; c < DEPTH; c++) begin
              acc_q[c] <= '0;
              acc_r[c] <= '0;
            end
          end else begin
            detect_rounds <= dr_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready) begin
      results.result_channel <= item.channel;
      results.pressed        <= pressed;
    end
  end

  a_detect_gives_result: assert property (@(posedge clk) disable iff (rst)
    (consume && in_use && !calibrating) |=> results.valid)
    else $error("detect sample did not load a result");

  a_round_in_range: assert property (@(posedge clk) disable iff (rst)
    calib_round < ROUND_W'(HISTORY_DEPTH))
    else $error("calibration round counter past history depth");

  a_round_idle_in_detect: assert property (@(posedge clk) disable iff (rst)
    !calibrating |-> calib_round == '0)
    else $error("calibration round counter nonzero in detect mode");

  a_detect_rounds_held: assert property (@(posedge clk) disable iff (rst)
    calibrating |-> detect_rounds == '0)
    else $error("detect round counter nonzero during calibration");

  a_rem_bounded: assert property (@(posedge clk) disable iff (rst)
    item_valid |-> RSUM_W'(acc_r[idx]) < RSUM_W'(HISTORY_DEPTH))
    else $error("accumulator remainder not below history depth");

endmodule

>>> rtl/multichannel_baseline_threshold_detector.sv
// multichannel baseline threshold detector, top level
// depends on mbtd_pkg, mbtd_intf, mbtd_regs, mbtd_split, mbtd_core
//
// Samples tagged with a channel come in on the samples channel, one request
// per cycle at full rate while results are taken; a request accepted goes into
// the input register, then quotient estimate, quotient correction, and the
// accumulate/compare stage loads the result register, and the block sustains
// one sample per cycle unless the result side stalls. The rate is set by the
// read-modify-write of the per-channel accumulators and the baseline compare,
// all done in one stage against flip-flop state, so consecutive samples of the
// same channel need no forwarding. After reset the block calibrates for
// HISTORY_DEPTH rounds, adding each channel's samples and giving no results; a
// round ends on any sample of the last channel in use. The sample closing the
// last round loads sum / HISTORY_DEPTH into every channel's baseline and
// switches to detect mode, where every in-use sample gives one result with
// pressed = sample > baseline + detect_offset. After recal_interval detect
// rounds (0 meaning 65536) the sums clear and calibration restarts. Samples on
// channels at or above the effective count (channel_count saturated to
// 1..MAX_CHANNELS) are dropped silently. There is no clearing pass: the
// accumulators, baselines and valid flags reset directly. Registers over APB:
// 0x0 channel_count, 0x4 detect_offset, 0x8 recal_interval; write only while
// no request is in flight.
module multichannel_baseline_threshold_detector #(
  parameter int MAX_CHANNELS  = 16,
  parameter int HISTORY_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // apb configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mbtd_pkg::ADDR_W-1:0]  paddr,
  input  logic [mbtd_pkg::DATA_W-1:0]  pwdata,
  output logic [mbtd_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  // sample requests and detection results
  mbtd_sample_if.sink                  samples,
  mbtd_result_if.source                results
);

  mbtd_pkg::cfg_t  cfg;
  mbtd_pkg::item_t item;
  logic            item_valid;
  logic            item_ready;

  // register file, fields go straight to the core
  mbtd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // front end: register the request and split the sample by the depth,
  // so the core only adds a quotient and a remainder
  mbtd_split #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_split (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  // calibration / detect state and the result register; it keeps taking
  // items while the result register is free or being drained
  mbtd_core #(
    .MAX_CHANNELS  (MAX_CHANNELS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .results    (results)
  );

endmodule

>>> tb/mbtd_press_checker.sv
`timescale 1ns / 1ps
// predicts and checks the detections of the multichannel baseline threshold detector
// depends on mbtd_pkg and mbtd_intf; watches the apb port, sample and result requests
module mbtd_press_checker #(
  parameter int MAX_CHANNELS  = 16,
  parameter int HISTORY_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mbtd_pkg::ADDR_W-1:0]   paddr,
  input  logic [mbtd_pkg::DATA_W-1:0]   pwdata,
  input  logic                          pready,
  mbtd_sample_if                        samples,
  mbtd_result_if                        results,
  output int                            fail_count,
  output int                            pending,
  output int                            judged,
  output int                            pressed_count,
  output int                            calib_count
);

  typedef struct packed {
    logic [mbtd_pkg::CH_W-1:0] channel;
    logic                      pressed;
  } detection_t;

  detection_t expected_detections[$];

  logic [mbtd_pkg::CNT_W-1:0] cfg_count;
  logic [mbtd_pkg::OFS_W-1:0] cfg_offset;
  logic [mbtd_pkg::RCL_W-1:0] cfg_recal;

  logic                       calibrating;
  int unsigned                calib_round;
  int unsigned                channel_sum[MAX_CHANNELS];
  logic [mbtd_pkg::SMP_W-1:0] baseline[MAX_CHANNELS];
  logic [mbtd_pkg::RCL_W-1:0] detect_rounds;

  // sampled on the falling edge: what shows here is taken by the next rising edge
  always @(negedge clk) begin
    detection_t  want;
    int unsigned in_use;
    int unsigned ch;
    int unsigned smp;
    if (rst) begin
      cfg_count     = mbtd_pkg::CHANNEL_COUNT_RST;
      cfg_offset    = mbtd_pkg::DETECT_OFFSET_RST;
      cfg_recal     = mbtd_pkg::RECAL_INTERVAL_RST;
      calibrating   = 1'b1;
      calib_round   = 0;
      detect_rounds = '0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        channel_sum[c] = 0;
        baseline[c]    = '0;
      end
      expected_detections.delete();
      fail_count    = 0;
      judged        = 0;
      pressed_count = 0;
      calib_count   = 0;
    end else begin
      if (results.valid && results.ready) begin
        if (expected_detections.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected detection: ch %0d pressed %0b", $time,
                   results.result_channel, results.pressed);
        end else begin
          want = expected_detections.pop_front();
          judged++;
          if (results.pressed) pressed_count++;
          if (want.channel !== results.result_channel || want.pressed !== results.pressed) begin
            fail_count++;
            $display("%0t: detection mismatch: expected ch %0d pressed %0b, got ch %0d pressed %0b",
                     $time, want.channel, want.pressed, results.result_channel, results.pressed);
          end
        end
      end

      if (psel && penable && pwrite && pready) begin
        case (paddr[mbtd_pkg::ADDR_W-1:2])
          mbtd_pkg::REG_CHANNEL_COUNT:  cfg_count  = mbtd_pkg::CNT_W'(pwdata);
          mbtd_pkg::REG_DETECT_OFFSET:  cfg_offset = mbtd_pkg::OFS_W'(pwdata);
          mbtd_pkg::REG_RECAL_INTERVAL: cfg_recal  = mbtd_pkg::RCL_W'(pwdata);
          default: ;
        endcase
      end

      if (samples.valid && samples.ready) begin
        ch     = 32'(samples.channel);
        smp    = 32'(samples.sample);
        in_use = (cfg_count < 1) ? 1 : (cfg_count > MAX_CHANNELS) ? MAX_CHANNELS : 32'(cfg_count);
        // channels past the count in use are dropped without a trace
        if (ch < in_use) begin
          if (calibrating) begin
            channel_sum[ch] += smp;
            if (ch == in_use - 1) begin
              calib_round++;
              if (calib_round >= HISTORY_DEPTH) begin
                for (int c = 0; c < MAX_CHANNELS; c++) begin
                  baseline[c]    = mbtd_pkg::SMP_W'(channel_sum[c] / HISTORY_DEPTH);
                  channel_sum[c] = 0;
                end
                calibrating   = 1'b0;
                calib_round   = 0;
                detect_rounds = '0;
                calib_count++;
              end
            end
          end else begin
            want.channel = mbtd_pkg::CH_W'(ch);
            want.pressed = (smp > int'(baseline[ch]) + int'(cfg_offset));
            expected_detections.push_back(want);
            if (ch == in_use - 1) begin
              detect_rounds = detect_rounds + 1'b1;
              if (detect_rounds == cfg_recal) begin
                detect_rounds = '0;
                calibrating   = 1'b1;
                calib_round   = 0;
                for (int c = 0; c < MAX_CHANNELS; c++) channel_sum[c] = 0;
              end
            end
          end
        end
      end
    end
    pending = expected_detections.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// testbench top for the multichannel baseline threshold detector: stimulus and verdict
// depends on mbtd_pkg, mbtd_intf, the detector rtl and mbtd_press_checker
module tb_top;

  localparam int MAX_CH        = 16;
  localparam int HIST          = 16;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int PHASES        = 14;
  localparam int SETTLE_CYCLES = 8;    // pipeline is four deep
  localparam int IDLE_LIMIT    = 5000;

  logic                        clk;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [mbtd_pkg::ADDR_W-1:0] paddr;
  logic [mbtd_pkg::DATA_W-1:0] pwdata;
  logic [mbtd_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  mbtd_sample_if samples ();
  mbtd_result_if results ();

  int fail_count;
  int pending;
  int judged;
  int pressed_count;
  int calib_count;

  int sent;
  int burst_left;
  int idle_cycles;

  // what the stimulus believes the registers hold
  int eff_count;
  int cur_offset;
  int cur_recal;

  // per channel signal level and noise of the current phase
  int level[MAX_CH];
  int spread;

  multichannel_baseline_threshold_detector #(
    .MAX_CHANNELS (MAX_CH),
    .HISTORY_DEPTH(HIST)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .samples(samples),
    .results(results)
  );

  mbtd_press_checker #(
    .MAX_CHANNELS (MAX_CH),
    .HISTORY_DEPTH(HIST)
  ) press_chk (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .samples      (samples),
    .results      (results),
    .fail_count   (fail_count),
    .pending      (pending),
    .judged       (judged),
    .pressed_count(pressed_count),
    .calib_count  (calib_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: any cycle that moves a request in either direction resets it
  always @(negedge clk) begin
    if (rst || (samples.valid && samples.ready) || (results.valid && results.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side stalls on its own: runs of always ready, light, medium and heavy stall
  initial begin
    int mode;
    int span;
    results.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0:       results.ready <= 1'b1;
          1:       results.ready <= ($urandom_range(0, 3) != 0);
          2:       results.ready <= ($urandom_range(0, 1) == 1);
          default: results.ready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  // setup phase, access phase, then psel low again before returning, so back to
  // back writes never drive psel twice in the same step
  task automatic write_reg(input mbtd_pkg::reg_idx_t idx,
                           input logic [mbtd_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= mbtd_pkg::ADDR_W'(int'(idx) * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // one sample request; the sender runs in bursts with random gaps between them
  task automatic send_sample(input logic [mbtd_pkg::CH_W-1:0] ch,
                             input logic [mbtd_pkg::SMP_W-1:0] smp);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        samples.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    samples.valid   <= 1'b1;
    samples.channel <= ch;
    samples.sample  <= smp;
    // ready is stable from the falling edge on, so the request goes at the next rise
    do @(negedge clk); while (!samples.ready);
    @(posedge clk);
    sent++;
  endtask

  // wait for every expected detection, then let dropped or calibrating
  // samples still in the pipe flush out
  task automatic settle();
    samples.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int cnt;
    int ofs;
    int rcl;
    int ch;
    int last_ch;
    int rr;
    int counted;
    int v;
    int r;
    int per_phase;

    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    samples.valid   = 1'b0;
    samples.channel = '0;
    samples.sample  = '0;
    sent            = 0;
    burst_left      = 0;
    per_phase       = RANDOM_ITEMS / PHASES;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: one channel, zero offset, recalibrate every second round
    write_reg(mbtd_pkg::REG_CHANNEL_COUNT, 1);
    write_reg(mbtd_pkg::REG_DETECT_OFFSET, 0);
    write_reg(mbtd_pkg::REG_RECAL_INTERVAL, 2);
    eff_count  = 1;
    cur_offset = 0;
    cur_recal  = 2;

    // calibration: fifteen full-scale samples and one zero, so the baseline
    // truncates 15345/16 down to 959; channels past the count are dropped
    for (int i = 0; i < 15; i++) begin
      send_sample(4'd0, 10'd1023);
      if (i == 4) send_sample(4'd15, 10'd0);
      if (i == 9) send_sample(4'd1, 10'd1023);
    end
    // the round that ends calibration gives no detection
    send_sample(4'd0, 10'd0);
    // one above the baseline is pressed, equal is not; the second round recalibrates
    send_sample(4'd0, 10'd960);
    send_sample(4'd5, 10'd1023);
    send_sample(4'd0, 10'd959);

    // random phases; the recal interval only grows between the short settings
    // so the round counter can never be left past it, the two huge intervals
    // come last
    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p == 0) begin
        cnt = 0;     // acts as a single channel
        ofs = 1023;
        rcl = 1;
      end else if (p == 1) begin
        cnt = 31;    // saturates to all channels
        ofs = $urandom_range(0, 15);
        rcl = 1;
      end else if (p == 2) begin
        cnt = MAX_CH;
        ofs = 0;
        rcl = 2;
      end else begin
        cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
        case ($urandom_range(0, 3))
          0:       ofs = 0;
          1:       ofs = $urandom_range(1, 40);
          2:       ofs = 1023;
          default: ofs = $urandom_range(0, 1023);
        endcase
        if (p == PHASES - 2) rcl = 65535;
        else if (p == PHASES - 1) rcl = 0;    // wraps to 65536 rounds
        else if (cur_recal < 6) rcl = cur_recal + $urandom_range(0, 1);
        else rcl = cur_recal;
      end

      // registers change with the block mid calibration or mid detection;
      // its counters carry over
      write_reg(mbtd_pkg::REG_CHANNEL_COUNT, cnt);
      eff_count = (cnt < 1) ? 1 : (cnt > MAX_CH) ? MAX_CH : cnt;
      if (p < 3 || $urandom_range(0, 2) != 0) begin
        write_reg(mbtd_pkg::REG_DETECT_OFFSET, ofs);
        cur_offset = ofs;
      end
      if (p < 3 || rcl != cur_recal || $urandom_range(0, 3) == 0) begin
        write_reg(mbtd_pkg::REG_RECAL_INTERVAL, rcl);
        cur_recal = rcl;
      end

      for (int c = 0; c < MAX_CH; c++) begin
        case ($urandom_range(0, 3))
          0:       level[c] = 0;
          1:       level[c] = 1023;
          default: level[c] = $urandom_range(0, 1023);
        endcase
      end
      spread = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 1023) : $urandom_range(0, 40);

      counted = 0;
      rr      = 0;
      last_ch = 0;
      while (counted < per_phase) begin
        // mostly clean round robin, with stray, repeated and skipped channels
        r = $urandom_range(0, 19);
        if (r < 2) begin
          ch = $urandom_range(0, MAX_CH - 1);
        end else if (r == 2) begin
          ch = last_ch;
        end else if (r == 3) begin
          rr = (rr + 1) % eff_count;
          ch = rr;
          rr = (rr + 1) % eff_count;
        end else begin
          ch = rr;
          rr = (rr + 1) % eff_count;
        end

        // samples scatter around the channel level, some around the threshold
        r = $urandom_range(0, 15);
        if (r == 0) begin
          v = $urandom_range(0, 1023);
        end else begin
          v = level[ch] + ((r < 5) ? cur_offset : 0);
          v = v + int'($urandom_range(0, 2 * spread)) - spread;
          if (v < 0) v = 0;
          if (v > 1023) v = 1023;
        end

        send_sample(mbtd_pkg::CH_W'(ch), mbtd_pkg::SMP_W'(v));
        last_ch = ch;
        if (ch < eff_count) counted++;
      end
    end

    settle();

    $display("%0d sample requests over %0d register settings, %0d calibrations completed",
             sent, PHASES + 1, calib_count);
    $display("%0d detections checked, %0d of them pressed", judged, pressed_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/mbtd_pkg.sv
rtl/mbtd_intf.sv
rtl/mbtd_regs.sv
rtl/mbtd_split.sv
rtl/mbtd_core.sv
rtl/multichannel_baseline_threshold_detector.sv
tb/mbtd_press_checker.sv
tb/tb_top.sv
